FILE: rtl/tcrt_pkg.sv
// Shared types and constants for the three-channel root counter timer.
`default_nettype none

package tcrt_pkg;

    // Default number of timers and the width of the irq pulse vector.
    localparam int TIMER_COUNT_DEF = 3;
    localparam int IRQ_W           = 3;
    localparam int SEL_TIMERS      = 3;

    // Configuration register map.
    localparam int            CFG_ADDR_W   = 3;
    localparam logic          CFG_REG_SCAN = 1'b0;
    localparam logic [15:0]   SCAN_DIV_RST = 16'd2146;

    // Request codes.
    localparam logic [2:0] REQ_TICK      = 3'd0;
    localparam logic [2:0] REQ_RD_COUNT  = 3'd1;
    localparam logic [2:0] REQ_RD_MODE   = 3'd2;
    localparam logic [2:0] REQ_RD_TARGET = 3'd3;
    localparam logic [2:0] REQ_WR_COUNT  = 3'd4;
    localparam logic [2:0] REQ_WR_MODE   = 3'd5;
    localparam logic [2:0] REQ_WR_TARGET = 3'd6;

    // Mode word bits.
    localparam logic [15:0] MODE_HALT2     = 16'h0001;
    localparam logic [15:0] MODE_RESTART   = 16'h0008;
    localparam logic [15:0] MODE_IRQ_TGT   = 16'h0010;
    localparam logic [15:0] MODE_IRQ_OVF   = 16'h0020;
    localparam logic [15:0] MODE_REPEAT    = 16'h0040;
    localparam logic [15:0] MODE_DIV_A     = 16'h0100;
    localparam logic [15:0] MODE_DIV8      = 16'h0200;
    localparam logic [15:0] MODE_REQ       = 16'h0400;
    localparam logic [15:0] MODE_HIT_TGT   = 16'h0800;
    localparam logic [15:0] MODE_HIT_OVF   = 16'h1000;
    localparam logic [15:0] MODE_READ_KEEP = 16'he7ff;

    localparam logic [16:0] COUNT_WRAP = 17'h0ffff;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  timer_select;
        logic [15:0] write_value;
    } t_req;

    typedef struct packed {
        logic [15:0] read_value;
        logic [2:0]  irq_pulses;
    } t_rsp;

    // Per-timer command, decoded once in the top level.
    typedef struct packed {
        logic        tick;
        logic        sel;
        logic [2:0]  kind;
        logic [15:0] value;
    } t_tmr_cmd;

endpackage

`default_nettype wire

FILE: rtl/tcrt_timer.sv
// One root counter: count, prescaler, mode, target and irq latch.
`default_nettype none

module tcrt_timer #(
    parameter int TIMER_IDX = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire tcrt_pkg::t_tmr_cmd i_cmd,
    input  wire logic [15:0]        i_scan_div,
    output logic [15:0]             o_rd_data,
    output logic                    o_irq
);
    import tcrt_pkg::*;

    logic [15:0] r_count, n_count;
    logic [15:0] r_pre,   n_pre;
    logic [15:0] r_mode,  n_mode;
    logic [15:0] r_target, n_target;
    logic        r_head,  n_head;
    logic        r_latch, n_latch;

    logic [16:0] w_rate;
    logic [16:0] w_next;
    logic        w_halt;
    logic        w_can_fire;

    // prescale ratio for this timer
    always_comb begin
        w_rate = 17'd1;
        if (TIMER_IDX == 0) begin
            if ((r_mode & MODE_DIV_A) != '0) w_rate = 17'd5;
        end else if (TIMER_IDX == 1) begin
            if ((r_mode & MODE_DIV_A) != '0) begin
                w_rate = (i_scan_div == '0) ? 17'd1 : {1'b0, i_scan_div};
            end
        end else if (TIMER_IDX == 2) begin
            if ((r_mode & MODE_DIV8) != '0) w_rate = 17'd8;
        end
    end

    assign w_halt     = (TIMER_IDX == 2) && ((r_mode & MODE_HALT2) != '0);
    assign w_next     = {1'b0, r_count} + 17'd1;
    assign w_can_fire = ((r_mode & MODE_REPEAT) != '0) || !r_latch;

    always_comb begin
        n_count   = r_count;
        n_pre     = r_pre;
        n_mode    = r_mode;
        n_target  = r_target;
        n_head    = r_head;
        n_latch   = r_latch;
        o_rd_data = '0;
        o_irq     = 1'b0;
        if (i_cmd.tick) begin
            if (!w_halt) begin
                if (({1'b0, r_pre} + 17'd1) >= w_rate) begin
                    n_pre = '0;
                    if (r_head && (w_next >= {1'b0, r_target})) begin
                        if ((r_mode & MODE_RESTART) != '0) begin
                            n_count = 16'(w_next - {1'b0, r_target});
                        end else begin
                            n_count = w_next[15:0];
                        end
                        n_head = n_count < r_target;
                        if (((r_mode & MODE_IRQ_TGT) != '0) && w_can_fire) begin
                            n_latch = 1'b1;
                            o_irq   = 1'b1;
                        end
                        n_mode = r_mode | MODE_HIT_TGT | MODE_REQ;
                    end else if (!r_head && (w_next >= COUNT_WRAP)) begin
                        n_count = 16'(w_next - COUNT_WRAP);
                        n_head  = n_count < r_target;
                        if (((r_mode & MODE_IRQ_OVF) != '0) && w_can_fire) begin
                            n_latch = 1'b1;
                            o_irq   = 1'b1;
                        end
                        n_mode = r_mode | MODE_HIT_OVF | MODE_REQ;
                    end else begin
                        n_count = w_next[15:0];
                    end
                end else begin
                    n_pre = r_pre + 16'd1;
                end
            end
        end else if (i_cmd.sel) begin
            unique case (i_cmd.kind)
                REQ_RD_COUNT: begin
                    o_rd_data = r_count;
                end
                REQ_RD_MODE: begin
                    o_rd_data = r_mode;
                    n_mode    = r_mode & MODE_READ_KEEP;
                end
                REQ_RD_TARGET: begin
                    o_rd_data = r_target;
                end
                REQ_WR_COUNT: begin
                    n_count = i_cmd.value;
                    n_head  = i_cmd.value < r_target;
                    n_pre   = '0;
                end
                REQ_WR_MODE: begin
                    n_mode  = i_cmd.value;
                    n_latch = 1'b0;
                    n_count = '0;
                    n_head  = r_target != '0;
                    n_pre   = '0;
                end
                REQ_WR_TARGET: begin
                    n_target = i_cmd.value;
                    n_head   = r_count < i_cmd.value;
                    n_pre    = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pre    <= '0;
            r_mode   <= '0;
            r_target <= '0;
            r_head   <= 1'b0;
            r_latch  <= 1'b0;
        end else if (i_en) begin
            r_count  <= n_count;
            r_pre    <= n_pre;
            r_mode   <= n_mode;
            r_target <= n_target;
            r_head   <= n_head;
            r_latch  <= n_latch;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/three_channel_root_timer.sv
// Top level of the three-channel root counter timer.
//
//  channel  | direction | payload  | handshake
//  ---------+-----------+----------+------------------------------
//  request  | in        | t_req    | i_in_valid / o_in_stall
//  response | out       | t_rsp    | o_out_valid / i_out_stall
//  config   | in        | 32b APB  | psel, penable, pwrite, pready
//
// One request per cycle, response in the cycle after accept: every timer
// computes its next state in a single pass and the response register holds
// the result. Reset (synchronous, active low) clears all timer state and
// loads the scanline divider with its default. The request side stalls only
// while the response register is full and the consumer is stalling.
`default_nettype none

module three_channel_root_timer #(
    parameter int TIMER_COUNT = tcrt_pkg::TIMER_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire tcrt_pkg::t_req                i_in_req,
    // response channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output tcrt_pkg::t_rsp                     o_out_rsp,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tcrt_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import tcrt_pkg::*;

    logic        r_out_valid;
    t_rsp        r_rsp;
    logic [15:0] r_scan_div;

    logic        w_accept;
    logic [15:0] w_rd [TIMER_COUNT];
    logic        w_irq [TIMER_COUNT];
    t_rsp        w_rsp;

    // A new request is taken whenever the response register can be refilled.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // APB: single register, zero-wait.
    assign pready = 1'b1;
    assign prdata = (paddr[CFG_ADDR_W-1] == CFG_REG_SCAN) ? {16'b0, r_scan_div} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_div <= SCAN_DIV_RST;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[CFG_ADDR_W-1] == CFG_REG_SCAN)) begin
            r_scan_div <= pwdata[15:0];
        end
    end

    // Timer instances. Only the first three are addressable by the bus.
    for (genvar gi = 0; gi < TIMER_COUNT; gi++) begin : g_tmr
        t_tmr_cmd w_cmd;

        always_comb begin
            w_cmd.tick  = i_in_req.req_type == REQ_TICK;
            w_cmd.sel   = (gi < SEL_TIMERS) && (i_in_req.timer_select == 2'(gi));
            w_cmd.kind  = i_in_req.req_type;
            w_cmd.value = i_in_req.write_value;
        end

        tcrt_timer #(
            .TIMER_IDX (gi)
        ) u_timer (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_accept),
            .i_cmd      (w_cmd),
            .i_scan_div (r_scan_div),
            .o_rd_data  (w_rd[gi]),
            .o_irq      (w_irq[gi])
        );
    end

    // Only the selected timer drives nonzero read data, so an OR merges them.
    always_comb begin
        w_rsp = '0;
        for (int k = 0; k < TIMER_COUNT; k++) begin
            w_rsp.read_value = w_rsp.read_value | w_rd[k];
        end
        for (int k = 0; k < IRQ_W; k++) begin
            if (k < TIMER_COUNT) w_rsp.irq_pulses[k] = w_irq[k];
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

endmodule

`default_nettype wire
